// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the event unpacker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DEU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DEU_ASSERT(label, clk, rst_n, prop, msg)
`define DEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/deu_pkg.sv =====
// Package with the types and constants of the digitizer event unpacker.
package deu_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int WORD_W       = 32;
    localparam int WORDS_W      = 28;
    localparam int DIVISOR_W    = 4;
    localparam int PRE_W        = 20;
    localparam int CH_W         = 3;
    localparam int IDX_W        = 29;
    localparam int SAMPLE_W     = 14;
    localparam int COUNTER_W    = 24;
    localparam int MASK_W       = 8;

    localparam logic [3:0]         HEADER_TAG   = 4'hA;
    localparam logic [WORDS_W-1:0] HEADER_WORDS = WORDS_W'(4);

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_SAMPLE   = 2'd1,
        KIND_BAD_TAG  = 2'd2,
        KIND_BAD_SIZE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_H0      = 3'd0,
        PH_H1      = 3'd1,
        PH_H2      = 3'd2,
        PH_H3      = 3'd3,
        PH_SAMPLES = 3'd4,
        PH_SPARE   = 3'd5,
        PH_PAD     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_DIV   = 2'd1,
        SEQ_EMIT0 = 2'd2,
        SEQ_EMIT1 = 2'd3
    } t_seq;

    typedef struct packed {
        t_kind                 kind;
        logic [CH_W-1:0]       channel;
        logic [IDX_W-1:0]      sample_index;
        logic [SAMPLE_W-1:0]   sample;
        logic [WORD_W-1:0]     time_stamp;
        logic [COUNTER_W-1:0]  event_counter;
        logic [MASK_W-1:0]     channel_mask;
        logic                  channel_last;
        logic                  last;
    } t_result;

    typedef struct packed {
        t_result               res0;
        t_result               res1;
        logic [1:0]            count;
        logic                  div_start;
        logic [DIVISOR_W-1:0]  divisor;
        logic [WORDS_W-1:0]    dividend;
    } t_step;

endpackage

// ===== src/deu_if.sv =====
// Valid/ready stream interfaces for readout words and decoded results.
interface deu_in_if;
    logic                         valid;
    logic                         ready;
    logic [deu_pkg::WORD_W-1:0]   data_word;
    logic                         bank_start;

    modport source(output valid, output data_word, output bank_start, input ready);
    modport sink(input valid, input data_word, input bank_start, output ready);
endinterface

interface deu_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic [deu_pkg::CH_W-1:0]       channel;
    logic [deu_pkg::IDX_W-1:0]      sample_index;
    logic [deu_pkg::SAMPLE_W-1:0]   sample;
    logic [deu_pkg::WORD_W-1:0]     time_stamp;
    logic [deu_pkg::COUNTER_W-1:0]  event_counter;
    logic [deu_pkg::MASK_W-1:0]     channel_mask;
    logic                           channel_last;
    logic                           last;

    modport source(output valid, output kind, output channel, output sample_index,
                   output sample, output time_stamp, output event_counter,
                   output channel_mask, output channel_last, output last, input ready);
    modport sink(input valid, input kind, input channel, input sample_index,
                 input sample, input time_stamp, input event_counter,
                 input channel_mask, input channel_last, input last, output ready);
endinterface

// ===== src/deu_divider.sv =====
// Iterative restoring divider that yields one quotient bit per cycle.
module deu_divider #(
    parameter int DIVIDEND_W = deu_pkg::WORDS_W,
    parameter int DIVISOR_W  = deu_pkg::DIVISOR_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_work, n_work;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_div, n_div;
    logic [DIVISOR_W:0]    w_trial;
    logic                  w_ge;

    assign w_trial = {r_rem, r_work[DIVIDEND_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W - 1);
            n_work = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = w_ge ? DIVISOR_W'(w_trial - {1'b0, r_div}) : w_trial[DIVISOR_W-1:0];
            n_work = {r_work[DIVIDEND_W-2:0], w_ge};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_work <= n_work;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

// ===== src/deu_parser.sv =====
// Event header and payload parser that holds the per-event state.
`include "assert_macros.svh"

module deu_parser #(
    parameter int CHANNELS = deu_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [deu_pkg::WORD_W-1:0]    i_data_word,
    input  logic                          i_bank_start,
    input  logic [deu_pkg::PRE_W-1:0]     i_pre_samples,
    input  logic                          i_div_done,
    input  logic [deu_pkg::WORDS_W-1:0]   i_quotient,
    output deu_pkg::t_step                o_step
);

    localparam int WORDS_W   = deu_pkg::WORDS_W;
    localparam int CH_W      = deu_pkg::CH_W;
    localparam int DIVISOR_W = deu_pkg::DIVISOR_W;
    localparam int WORD_W    = deu_pkg::WORD_W;

    deu_pkg::t_phase                r_phase, n_phase;
    logic [WORDS_W-1:0]             r_words_left, n_words_left;
    logic [deu_pkg::MASK_W-1:0]     r_mask_held, n_mask_held;
    logic [deu_pkg::COUNTER_W-1:0]  r_counter_held, n_counter_held;
    logic [WORDS_W-1:0]             r_wpc, n_wpc;
    logic [WORDS_W-1:0]             r_wic, n_wic;
    logic [CH_W-1:0]                r_cur_ch, n_cur_ch;
    logic                           r_pad_pending, n_pad_pending;
    logic                           r_locked, n_locked;

    deu_pkg::t_phase                v_phase;
    logic                           v_locked;
    logic [DIVISOR_W-1:0]           v_enabled;
    logic [CH_W-1:0]                v_first;
    logic [CH_W-1:0]                v_next;
    logic                           v_next_found;
    logic [WORDS_W-1:0]             v_wic_inc;
    logic                           v_chl;
    logic [WORDS_W-1:0]             v_size;

    always_comb begin
        v_enabled    = '0;
        v_first      = '0;
        v_next       = '0;
        v_next_found = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            v_enabled = v_enabled + DIVISOR_W'(i_data_word[ch]);
        end
        for (int ch = CHANNELS - 1; ch >= 0; ch--) begin
            if (r_mask_held[ch]) begin
                v_first = CH_W'(ch);
                if (CH_W'(ch) > r_cur_ch) begin
                    v_next       = CH_W'(ch);
                    v_next_found = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_words_left   = r_words_left;
        n_mask_held    = r_mask_held;
        n_counter_held = r_counter_held;
        n_wpc          = r_wpc;
        n_wic          = r_wic;
        n_cur_ch       = r_cur_ch;
        n_pad_pending  = r_pad_pending;
        n_locked       = r_locked;
        o_step         = '0;
        o_step.dividend = r_words_left;
        o_step.divisor  = v_enabled;
        v_phase        = r_phase;
        v_locked       = r_locked;
        v_wic_inc      = r_wic + WORDS_W'(1);
        v_chl          = (v_wic_inc >= r_wpc);
        v_size         = i_data_word[WORDS_W-1:0];

        if (i_step) begin
            if (i_bank_start) begin
                v_locked = 1'b0;
                v_phase  = deu_pkg::PH_H0;
            end
            n_locked = v_locked;
            n_phase  = v_phase;
            if (!v_locked) begin
                case (v_phase)
                    deu_pkg::PH_H1: begin
                        n_mask_held = i_data_word[deu_pkg::MASK_W-1:0];
                        if (v_enabled == '0) begin
                            n_locked         = 1'b1;
                            n_phase          = deu_pkg::PH_H0;
                            o_step.res0.kind = deu_pkg::KIND_BAD_SIZE;
                            o_step.res0.last = 1'b1;
                            o_step.count     = 2'd1;
                        end else begin
                            n_phase          = deu_pkg::PH_H2;
                            o_step.div_start = 1'b1;
                        end
                    end
                    deu_pkg::PH_H2: begin
                        n_counter_held = i_data_word[deu_pkg::COUNTER_W-1:0];
                        n_phase        = deu_pkg::PH_H3;
                    end
                    deu_pkg::PH_H3: begin
                        o_step.res0.kind          = deu_pkg::KIND_HEADER;
                        o_step.res0.time_stamp    = i_data_word - WORD_W'(i_pre_samples);
                        o_step.res0.event_counter = r_counter_held;
                        o_step.res0.channel_mask  = r_mask_held;
                        o_step.res0.last          = 1'b1;
                        o_step.count              = 2'd1;
                        n_wic = '0;
                        if (r_wpc == '0) begin
                            n_phase = deu_pkg::PH_SPARE;
                        end else begin
                            n_cur_ch = v_first;
                            n_phase  = deu_pkg::PH_SAMPLES;
                        end
                        if (r_words_left == '0) begin
                            n_phase = r_pad_pending ? deu_pkg::PH_PAD : deu_pkg::PH_H0;
                        end
                    end
                    deu_pkg::PH_SAMPLES: begin
                        o_step.res0.kind          = deu_pkg::KIND_SAMPLE;
                        o_step.res0.channel       = r_cur_ch;
                        o_step.res0.sample_index  = {r_wic, 1'b0};
                        o_step.res0.sample        = i_data_word[13:0];
                        o_step.res0.event_counter = r_counter_held;
                        o_step.res0.channel_mask  = r_mask_held;
                        o_step.res1               = o_step.res0;
                        o_step.res1.sample_index  = {r_wic, 1'b1};
                        o_step.res1.sample        = i_data_word[29:16];
                        o_step.res1.channel_last  = v_chl;
                        o_step.res1.last          = 1'b1;
                        o_step.count              = 2'd2;
                        n_wic = v_wic_inc;
                        if (v_chl) begin
                            if (v_next_found) begin
                                n_cur_ch = v_next;
                                n_wic    = '0;
                            end else begin
                                n_phase = deu_pkg::PH_SPARE;
                            end
                        end
                        if (r_words_left != '0) begin
                            n_words_left = r_words_left - WORDS_W'(1);
                        end
                        if (n_words_left == '0) begin
                            n_phase = r_pad_pending ? deu_pkg::PH_PAD : deu_pkg::PH_H0;
                        end
                    end
                    deu_pkg::PH_SPARE: begin
                        if (r_words_left != '0) begin
                            n_words_left = r_words_left - WORDS_W'(1);
                        end
                        if (n_words_left == '0) begin
                            n_phase = r_pad_pending ? deu_pkg::PH_PAD : deu_pkg::PH_H0;
                        end
                    end
                    deu_pkg::PH_PAD: begin
                        n_pad_pending = 1'b0;
                        n_phase       = deu_pkg::PH_H0;
                    end
                    default: begin
                        if (i_data_word[WORD_W-1:WORD_W-4] != deu_pkg::HEADER_TAG) begin
                            n_locked         = 1'b1;
                            n_phase          = deu_pkg::PH_H0;
                            o_step.res0.kind = deu_pkg::KIND_BAD_TAG;
                            o_step.res0.last = 1'b1;
                            o_step.count     = 2'd1;
                        end else if (v_size < deu_pkg::HEADER_WORDS) begin
                            n_locked         = 1'b1;
                            n_phase          = deu_pkg::PH_H0;
                            o_step.res0.kind = deu_pkg::KIND_BAD_SIZE;
                            o_step.res0.last = 1'b1;
                            o_step.count     = 2'd1;
                        end else begin
                            n_words_left  = v_size - deu_pkg::HEADER_WORDS;
                            n_pad_pending = v_size[0];
                            n_phase       = deu_pkg::PH_H1;
                        end
                    end
                endcase
            end
        end

        if (i_div_done) begin
            n_wpc = i_quotient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= deu_pkg::PH_H0;
            r_words_left   <= '0;
            r_mask_held    <= '0;
            r_counter_held <= '0;
            r_wpc          <= '0;
            r_wic          <= '0;
            r_cur_ch       <= '0;
            r_pad_pending  <= 1'b0;
            r_locked       <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_words_left   <= n_words_left;
            r_mask_held    <= n_mask_held;
            r_counter_held <= n_counter_held;
            r_wpc          <= n_wpc;
            r_wic          <= n_wic;
            r_cur_ch       <= n_cur_ch;
            r_pad_pending  <= n_pad_pending;
            r_locked       <= n_locked;
        end
    end

    // While samples are read out, the current channel is always an enabled one.
    `DEU_ASSERT(a_cur_ch_enabled, i_clk, i_rst_n, (r_phase != deu_pkg::PH_SAMPLES) || r_mask_held[r_cur_ch], "sample channel is not enabled")

endmodule

// ===== src/digitizer_event_unpacker.sv =====
// Top level of the digitizer event unpacker.
// The block reads a digitizer readout bank over the i_in channel, one 32-bit
// word per request, with bank_start set on the first word of a bank. Decoded
// results leave over the o_res channel: one header result per event, two
// samples per sample word, and one error result for a bad tag, a bad size or
// an empty channel mask, after which words are dropped until the next bank.
// The presample count is to be written over i_cfg_we and i_cfg_wdata only
// while idle; the block itself does not enforce this. A taken word's first
// result is shown in the next cycle and the second, if any, once the first
// has been taken. Header word one also starts the divider that splits the
// payload over the enabled channels, which holds i_in.ready low until the
// division is done. A word with results holds off the next word until all
// of its results have been taken. When the receiver stalls, the result is
// held and no new word is taken. A synchronous reset clears the event
// state, the presample count and any pending results.
`include "assert_macros.svh"

module digitizer_event_unpacker #(
    parameter int CHANNELS = deu_pkg::CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [deu_pkg::PRE_W-1:0]  i_cfg_wdata,
    deu_in_if.sink                     i_in,
    deu_out_if.source                  o_res
);

    deu_pkg::t_seq                 r_seq, n_seq;
    logic [deu_pkg::PRE_W-1:0]     r_pre_samples;
    deu_pkg::t_result              r_res0, r_res1;
    logic [1:0]                    r_count;
    deu_pkg::t_result              w_res;
    deu_pkg::t_step                w_step;
    logic                          w_accept;
    logic                          w_ready;
    logic                          w_out_valid;
    logic                          w_div_busy;
    logic                          w_div_done;
    logic [deu_pkg::WORDS_W-1:0]   w_quotient;

    assign w_accept = i_in.valid && w_ready;

    deu_parser #(
        .CHANNELS(CHANNELS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_accept),
        .i_data_word  (i_in.data_word),
        .i_bank_start (i_in.bank_start),
        .i_pre_samples(r_pre_samples),
        .i_div_done   (w_div_done),
        .i_quotient   (w_quotient),
        .o_step       (w_step)
    );

    deu_divider #(
        .DIVIDEND_W(deu_pkg::WORDS_W),
        .DIVISOR_W (deu_pkg::DIVISOR_W)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_step.div_start),
        .i_dividend(w_step.dividend),
        .i_divisor (w_step.divisor),
        .o_busy    (w_div_busy),
        .o_done    (w_div_done),
        .o_quotient(w_quotient)
    );

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            deu_pkg::SEQ_IDLE: begin
                if (w_accept) begin
                    if (w_step.div_start) begin
                        n_seq = deu_pkg::SEQ_DIV;
                    end else if (w_step.count != 2'd0) begin
                        n_seq = deu_pkg::SEQ_EMIT0;
                    end
                end
            end
            deu_pkg::SEQ_DIV: begin
                if (w_div_done) begin
                    n_seq = deu_pkg::SEQ_IDLE;
                end
            end
            deu_pkg::SEQ_EMIT0: begin
                if (o_res.ready) begin
                    n_seq = (r_count == 2'd2) ? deu_pkg::SEQ_EMIT1 : deu_pkg::SEQ_IDLE;
                end
            end
            deu_pkg::SEQ_EMIT1: begin
                if (o_res.ready) begin
                    n_seq = deu_pkg::SEQ_IDLE;
                end
            end
            default: begin
                n_seq = deu_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ready     = 1'b0;
        w_out_valid = 1'b0;
        w_res       = r_res0;
        case (r_seq)
            deu_pkg::SEQ_IDLE: begin
                w_ready = 1'b1;
            end
            deu_pkg::SEQ_EMIT0: begin
                w_out_valid = 1'b1;
            end
            deu_pkg::SEQ_EMIT1: begin
                w_out_valid = 1'b1;
                w_res       = r_res1;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= deu_pkg::SEQ_IDLE;
            r_pre_samples <= '0;
            r_count       <= 2'd0;
        end else begin
            r_seq <= n_seq;
            if (i_cfg_we) begin
                r_pre_samples <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_count <= w_step.count;
            end
        end
        if (w_accept) begin
            r_res0 <= w_step.res0;
            r_res1 <= w_step.res1;
        end
    end

    assign i_in.ready          = w_ready;
    assign o_res.valid         = w_out_valid;
    assign o_res.kind          = w_res.kind;
    assign o_res.channel       = w_res.channel;
    assign o_res.sample_index  = w_res.sample_index;
    assign o_res.sample        = w_res.sample;
    assign o_res.time_stamp    = w_res.time_stamp;
    assign o_res.event_counter = w_res.event_counter;
    assign o_res.channel_mask  = w_res.channel_mask;
    assign o_res.channel_last  = w_res.channel_last;
    assign o_res.last          = w_res.last;

    // A new word is never taken while a result is on offer.
    `DEU_ASSERT(a_ready_excl, i_clk, i_rst_n, !(w_ready && w_out_valid),
                "ready while result pending")
    // The divider runs only while input is held off.
    `DEU_ASSERT(a_div_stall, i_clk, i_rst_n, !(w_div_busy && w_ready),
                "ready while dividing")
    // A result that is not the last of its word is followed by another one.
    `DEU_ASSERT_NEXT(a_second_result, i_clk, i_rst_n, w_out_valid && !w_res.last,
                     w_out_valid, "second result lost")
    // A word without results and without division leaves the block ready.
    `DEU_ASSERT_NEXT(a_quiet_word, i_clk, i_rst_n,
                     w_accept && (w_step.count == 2'd0) && !w_step.div_start,
                     w_ready, "block stuck after quiet word")

endmodule

// ===== tb/sv/tb_digitizer_event_unpacker.sv =====
// Self-checking testbench for the digitizer event unpacker, with its own decoder of readout words.
module tb_digitizer_event_unpacker;
    import deu_pkg::*;

    localparam int NUM_CHANNELS = CHANNELS_DEF;
    localparam logic [MASK_W-1:0] USABLE_BITS = MASK_W'((1 << NUM_CHANNELS) - 1);
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              bank_start;
    } t_readout;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [PRE_W-1:0] i_cfg_wdata;

    deu_in_if  in_if();
    deu_out_if res_if();

    digitizer_event_unpacker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_res       (res_if)
    );

    always #5 i_clk = ~i_clk;

    t_readout readout_words[$];
    t_result  pending_results[$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    logic     hold_on = 1'b0;
    logic     pressure_go = 1'b0;
    logic     bank_needed = 1'b0;

    // Decoder state, kept alongside the block.
    logic [PRE_W-1:0]     pre_copy;
    t_phase               ph;
    logic [WORDS_W-1:0]   words_left;
    logic [MASK_W-1:0]    mask_held;
    logic [COUNTER_W-1:0] counter_held;
    logic [WORDS_W-1:0]   words_per_ch;
    logic [WORDS_W-1:0]   word_in_ch;
    logic [CH_W-1:0]      cur_ch;
    logic                 pad_pending;
    logic                 locked_out;

    function automatic int first_channel_from(input logic [MASK_W-1:0] m, input int from);
        for (int c = from; c < NUM_CHANNELS; c++) begin
            if (m[c]) begin
                return c;
            end
        end
        return NUM_CHANNELS;
    endfunction

    task automatic expect_result(input t_result r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic close_payload();
        if (words_left == '0) begin
            ph = pad_pending ? PH_PAD : PH_H0;
        end
    endtask

    task automatic decode_word(input logic [WORD_W-1:0] w, input logic bs);
        t_result r0;
        t_result r1;
        int n;
        int nxt;
        logic [WORDS_W-1:0] size;
        logic [IDX_W-1:0] idx;
        logic chl;
        r0 = '0;
        r1 = '0;
        if (bs) begin
            locked_out = 1'b0;
            ph = PH_H0;
        end
        if (locked_out) begin
            return;
        end
        case (ph)
            PH_H1: begin
                mask_held = w[MASK_W-1:0];
                n = $countones(mask_held & USABLE_BITS);
                if (n == 0) begin
                    locked_out = 1'b1;
                    ph = PH_H0;
                    r0.kind = KIND_BAD_SIZE;
                    r0.last = 1'b1;
                    expect_result(r0);
                end else begin
                    words_per_ch = WORDS_W'(int'(words_left) / n);
                    ph = PH_H2;
                end
            end
            PH_H2: begin
                counter_held = w[COUNTER_W-1:0];
                ph = PH_H3;
            end
            PH_H3: begin
                r0.kind = KIND_HEADER;
                r0.time_stamp = w - WORD_W'(pre_copy);
                r0.event_counter = counter_held;
                r0.channel_mask = mask_held;
                r0.last = 1'b1;
                expect_result(r0);
                word_in_ch = '0;
                if (words_per_ch == '0) begin
                    ph = PH_SPARE;
                end else begin
                    cur_ch = CH_W'(first_channel_from(mask_held & USABLE_BITS, 0));
                    ph = PH_SAMPLES;
                end
                close_payload();
            end
            PH_SAMPLES: begin
                idx = {word_in_ch, 1'b0};
                word_in_ch = word_in_ch + 1'b1;
                chl = (word_in_ch >= words_per_ch);
                r0.kind = KIND_SAMPLE;
                r0.channel = cur_ch;
                r0.sample_index = idx;
                r0.sample = w[SAMPLE_W-1:0];
                r0.event_counter = counter_held;
                r0.channel_mask = mask_held;
                r1 = r0;
                r1.sample_index = idx + 1'b1;
                r1.sample = w[16 +: SAMPLE_W];
                r1.channel_last = chl;
                r1.last = 1'b1;
                expect_result(r0);
                expect_result(r1);
                if (chl) begin
                    nxt = first_channel_from(mask_held & USABLE_BITS, int'(cur_ch) + 1);
                    if (nxt < NUM_CHANNELS) begin
                        cur_ch = CH_W'(nxt);
                        word_in_ch = '0;
                    end else begin
                        ph = PH_SPARE;
                    end
                end
                if (words_left != '0) begin
                    words_left = words_left - 1'b1;
                end
                close_payload();
            end
            PH_SPARE: begin
                if (words_left != '0) begin
                    words_left = words_left - 1'b1;
                end
                close_payload();
            end
            PH_PAD: begin
                pad_pending = 1'b0;
                ph = PH_H0;
            end
            default: begin
                size = w[WORDS_W-1:0];
                if (w[31:28] != HEADER_TAG) begin
                    locked_out = 1'b1;
                    ph = PH_H0;
                    r0.kind = KIND_BAD_TAG;
                    r0.last = 1'b1;
                    expect_result(r0);
                end else if (size < HEADER_WORDS) begin
                    locked_out = 1'b1;
                    ph = PH_H0;
                    r0.kind = KIND_BAD_SIZE;
                    r0.last = 1'b1;
                    expect_result(r0);
                end else begin
                    words_left = size - HEADER_WORDS;
                    pad_pending = size[0];
                    ph = PH_H1;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] exp_v);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got_v, exp_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : drive_words
        t_readout nxt_w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_word(in_if.data_word, in_if.bank_start);
            end
            if (!in_if.valid || in_if.ready) begin
                if (readout_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_w = readout_words.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.data_word <= nxt_w.word;
                    in_if.bank_start <= nxt_w.bank_start;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request behind it", 32'(res_if.kind), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.kind !== want.kind)
                        report_mismatch("kind", 32'(res_if.kind), 32'(want.kind));
                    if (res_if.channel !== want.channel)
                        report_mismatch("channel", 32'(res_if.channel), 32'(want.channel));
                    if (res_if.sample_index !== want.sample_index)
                        report_mismatch("sample_index", 32'(res_if.sample_index),
                                        32'(want.sample_index));
                    if (res_if.sample !== want.sample)
                        report_mismatch("sample", 32'(res_if.sample), 32'(want.sample));
                    if (res_if.time_stamp !== want.time_stamp)
                        report_mismatch("time_stamp", res_if.time_stamp, want.time_stamp);
                    if (res_if.event_counter !== want.event_counter)
                        report_mismatch("event_counter", 32'(res_if.event_counter),
                                        32'(want.event_counter));
                    if (res_if.channel_mask !== want.channel_mask)
                        report_mismatch("channel_mask", 32'(res_if.channel_mask),
                                        32'(want.channel_mask));
                    if (res_if.channel_last !== want.channel_last)
                        report_mismatch("channel_last", 32'(res_if.channel_last),
                                        32'(want.channel_last));
                    if (res_if.last !== want.last)
                        report_mismatch("last", 32'(res_if.last), 32'(want.last));
                end
            end
            res_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The long receiver hold-off lets the block fill up and stall its input.
    initial begin
        wait (pressure_go);
        repeat (20) @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    task automatic queue_word(input logic [WORD_W-1:0] w, input logic bs);
        t_readout item;
        item.word = w;
        item.bank_start = bs;
        readout_words.insert(readout_words.size(), item);
    endtask

    task automatic queue_junk(input int n);
        for (int j = 0; j < n; j++) begin
            queue_word($urandom, 1'b0);
        end
    endtask

    task automatic queue_event(input logic bs, input logic [WORDS_W-1:0] size,
                               input logic [MASK_W-1:0] mask, input logic [COUNTER_W-1:0] cnt,
                               input logic [WORD_W-1:0] trig, input int limit,
                               output int pushed);
        logic [WORD_W-1:0] words[$];
        int total;
        total = int'(size) + int'(size[0]);
        pushed = (limit >= 0 && limit < total) ? limit : total;
        words.insert(words.size(), {HEADER_TAG, size});
        words.insert(words.size(), {24'($urandom), mask});
        words.insert(words.size(), {8'($urandom), cnt});
        words.insert(words.size(), trig);
        while (words.size() < pushed) begin
            words.insert(words.size(), $urandom);
        end
        for (int j = 0; j < pushed; j++) begin
            queue_word(words[j], (j == 0) ? bs : 1'b0);
        end
    endtask

    task automatic queue_directed();
        int pushed;
        logic [WORD_W-1:0] bad_tag_word;
        bad_tag_word = 32'h0FFF_FFFF;
        queue_event(1'b1, 28'd6, 8'h01, 24'hFF_FFFF, 32'h0, 4, pushed);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'h0000_0000, 1'b0);
        queue_event(1'b0, 28'd7, 8'h84, 24'h0, 32'hFFFF_FFFF, -1, pushed);
        queue_event(1'b0, 28'd4, 8'hFF, 24'h12_3456, $urandom, -1, pushed);
        queue_word(bad_tag_word, 1'b0);
        queue_word({HEADER_TAG, 28'd8}, 1'b0);
        queue_word({HEADER_TAG, 28'd3}, 1'b1);
        queue_event(1'b1, 28'd8, 8'h00, 24'h1, $urandom, 2, pushed);
        queue_event(1'b1, 28'd12, 8'h03, 24'h2, $urandom, 5, pushed);
        bank_needed = 1'b1;
    endtask

    task automatic queue_random(input int target);
        int made;
        int r;
        int pushed;
        int tag;
        logic bs;
        logic [WORDS_W-1:0] size;
        logic [MASK_W-1:0] mask;
        logic [WORD_W-1:0] w;
        made = 0;
        while (made < target) begin
            r = $urandom_range(99);
            bs = bank_needed || ($urandom_range(3) == 0);
            bank_needed = 1'b0;
            if ($urandom_range(9) < 3) begin
                mask = 8'(1 << $urandom_range(NUM_CHANNELS - 1));
            end else begin
                mask = 8'($urandom_range(1, 255));
            end
            if ($urandom_range(9) == 0) begin
                size = 28'(4 + $urandom_range(0, 60));
            end else begin
                size = 28'(4 + $urandom_range(0, 20));
            end
            if (r < 70) begin
                queue_event(bs, size, mask, 24'($urandom), $urandom, -1, pushed);
                made += pushed;
            end else if (r < 78) begin
                queue_event(bs, 28'($urandom), 8'($urandom), 24'($urandom), $urandom,
                            $urandom_range(1, 10), pushed);
                made += pushed;
                bank_needed = 1'b1;
            end else if (r < 84) begin
                tag = $urandom_range(14);
                if (tag >= 10) begin
                    tag++;
                end
                w = $urandom;
                w[31:28] = 4'(tag);
                queue_word(w, bs);
                queue_junk($urandom_range(0, 3));
                made += 1;
                bank_needed = 1'b1;
            end else if (r < 89) begin
                queue_word({HEADER_TAG, 28'($urandom_range(3))}, bs);
                queue_junk($urandom_range(0, 3));
                made += 1;
                bank_needed = 1'b1;
            end else if (r < 94) begin
                queue_event(bs, size, 8'h00, 24'($urandom), $urandom, 2, pushed);
                queue_junk($urandom_range(0, 3));
                made += pushed;
                bank_needed = 1'b1;
            end else begin
                mask = mask | 8'hF0;
                size = 28'(4 + $urandom_range(0, $countones(mask) - 1));
                queue_event(bs, size, mask, 24'($urandom), $urandom, -1, pushed);
                made += pushed;
            end
        end
    endtask

    task automatic write_pre_samples(input logic [PRE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pre_copy = v;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (readout_words.size() != 0 || in_if.valid || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [PRE_W-1:0] pre, input int send_pct,
                             input int recv_pct, input int target);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
        write_pre_samples(pre);
        @(negedge i_clk);
        queue_random(target);
        wait_idle();
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.data_word = '0;
        in_if.bank_start = 1'b0;
        res_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        pre_copy = '0;
        ph = PH_H0;
        words_left = '0;
        mask_held = '0;
        counter_held = '0;
        words_per_ch = '0;
        word_in_ch = '0;
        cur_ch = '0;
        pad_pending = 1'b0;
        locked_out = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_pre_samples(20'h00010);
        @(negedge i_clk);
        queue_directed();
        wait_idle();

        run_phase(20'hF_FFFF, 0, 0, 180);
        run_phase(PRE_W'($urandom), 59, 0, 180);
        run_phase(20'h0_0000, 0, 59, 180);
        run_phase(PRE_W'($urandom), 19, 19, 180);
        pressure_go <= 1'b1;
        run_phase(PRE_W'($urandom), 0, 0, 100);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/deu_pkg.sv
src/deu_if.sv
src/deu_divider.sv
src/deu_parser.sv
src/digitizer_event_unpacker.sv
tb/sv/tb_digitizer_event_unpacker.sv
